[rtl/core/itoa_pkg.sv]
// Shared types, codes and character helpers of the integer-to-ASCII formatter.
`default_nettype none
package itoa_pkg;

   localparam int REQ_VALUE_BITS = 32;

   localparam logic [2:0] KIND_DEC  = 3'd0;
   localparam logic [2:0] KIND_OCT  = 3'd1;
   localparam logic [2:0] KIND_HEXL = 3'd2;
   localparam logic [2:0] KIND_HEXU = 3'd3;
   localparam logic [2:0] KIND_BIN  = 3'd4;

   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_X_LOWER = 8'h78;
   localparam logic [7:0] CHAR_X_UPPER = 8'h58;
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;
   localparam logic [7:0] CHAR_A_UPPER = 8'h41;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   typedef struct packed {
      logic      load;
      logic      step;
      logic      shift;
      radix_type radix;
   } conv_cmd_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] text_char;
      logic       last_char;
   } emit_type;

   function automatic int dec_digit_count(input int bits);
      return (bits * 30103) / 100000 + 1;
   endfunction

   function automatic int oct_group_count(input int bits);
      return (bits + 2) / 3;
   endfunction

   function automatic int hex_group_count(input int bits);
      return (bits + 3) / 4;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
      logic [7:0] base;
      if (digit < 4'd10) begin
         return CHAR_ZERO + {4'd0, digit};
      end
      base = upper ? CHAR_A_UPPER : CHAR_A_LOWER;
      return base + {4'd0, digit} - 8'd10;
   endfunction

endpackage
`default_nettype wire

[rtl/core/itoa_conv.sv]
// Shared shift/add-3 unit: binary-to-BCD conversion and digit shift-out.
`default_nettype none
module itoa_conv #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                    clock,
   input  wire itoa_pkg::conv_cmd_type  cmd,
   input  wire logic [VALUE_BITS-1:0]   load_value,
   output logic [3:0]                   digit
);
   import itoa_pkg::*;

   localparam int NDEC = dec_digit_count(VALUE_BITS);
   localparam int NOCT = oct_group_count(VALUE_BITS);
   localparam int NHEX = hex_group_count(VALUE_BITS);
   localparam int SW   = 4 * NDEC;

   logic [SW-1:0]         sh_ff;
   logic [SW-1:0]         sh_in;
   logic [SW-1:0]         adj;
   logic [VALUE_BITS-1:0] bin_ff;
   logic [VALUE_BITS-1:0] bin_in;

   always_comb begin
      adj = sh_ff;
      for (int i = 0; i < NDEC; i++) begin
         if (sh_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = sh_ff[4*i +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      sh_in  = sh_ff;
      bin_in = bin_ff;
      if (cmd.load) begin
         case (cmd.radix)
            RADIX_DEC: begin
               sh_in  = '0;
               bin_in = load_value;
            end
            RADIX_OCT: sh_in = SW'(load_value) << (SW - 3 * NOCT);
            RADIX_HEX: sh_in = SW'(load_value) << (SW - 4 * NHEX);
            RADIX_BIN: sh_in = SW'(load_value) << (SW - VALUE_BITS);
            default:   sh_in = '0;
         endcase
      end else if (cmd.step) begin
         sh_in  = {adj[SW-2:0], bin_ff[VALUE_BITS-1]};
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
      end else if (cmd.shift) begin
         case (cmd.radix)
            RADIX_OCT: sh_in = {sh_ff[SW-4:0], 3'b000};
            RADIX_BIN: sh_in = {sh_ff[SW-2:0], 1'b0};
            default:   sh_in = {sh_ff[SW-5:0], 4'b0000};
         endcase
      end
   end

   always_comb begin
      case (cmd.radix)
         RADIX_OCT: digit = {1'b0, sh_ff[SW-1 -: 3]};
         RADIX_BIN: digit = {3'b000, sh_ff[SW-1]};
         default:   digit = sh_ff[SW-1 -: 4];
      endcase
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      bin_ff <= bin_in;
   end

endmodule
`default_nettype wire

[rtl/core/itoa_ctrl.sv]
// Sequencer: decode, sign and prefix, conversion steps and leading-zero skip.
`default_nettype none
module itoa_ctrl #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [2:0]                          req_kind,
   input  wire logic [itoa_pkg::REQ_VALUE_BITS-1:0] req_value,
   input  wire logic                                req_show_plus,
   input  wire logic                                req_blank_plus,
   input  wire logic                                req_alt_prefix,
   input  wire logic                                out_free,
   input  wire logic [3:0]                          digit,
   output itoa_pkg::conv_cmd_type                   cmd,
   output logic [VALUE_BITS-1:0]                    load_value,
   output itoa_pkg::emit_type                       emit
);
   import itoa_pkg::*;

   localparam int NDEC = dec_digit_count(VALUE_BITS);
   localparam int NOCT = oct_group_count(VALUE_BITS);
   localparam int NHEX = hex_group_count(VALUE_BITS);
   localparam int CW   = $clog2(VALUE_BITS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_HEAD = 4'b0100,
      ST_DIGS = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   radix_type             radix_ff, radix_in;
   logic                  upper_ff, upper_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [1:0]            head_cnt_ff, head_cnt_in;
   logic [7:0]            head_a_ff, head_a_in;
   logic [7:0]            head_b_ff, head_b_in;
   logic                  lead_ff, lead_in;
   radix_type             req_radix;
   logic [VALUE_BITS-1:0] word;
   logic                  neg;
   logic [CW-1:0]         dig_cnt;

   always_comb begin
      case (req_kind)
         KIND_OCT:            req_radix = RADIX_OCT;
         KIND_HEXL, KIND_HEXU: req_radix = RADIX_HEX;
         KIND_BIN:            req_radix = RADIX_BIN;
         default:             req_radix = RADIX_DEC;
      endcase
      word       = VALUE_BITS'(req_value);
      neg        = (req_radix == RADIX_DEC) && word[VALUE_BITS-1];
      load_value = neg ? (~word + VALUE_BITS'(1)) : word;
      case (state_ff == ST_IDLE ? req_radix : radix_ff)
         RADIX_OCT: dig_cnt = CW'(NOCT);
         RADIX_HEX: dig_cnt = CW'(NHEX);
         RADIX_BIN: dig_cnt = CW'(VALUE_BITS);
         default:   dig_cnt = CW'(NDEC);
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      radix_in    = radix_ff;
      upper_in    = upper_ff;
      cnt_in      = cnt_ff;
      head_cnt_in = head_cnt_ff;
      head_a_in   = head_a_ff;
      head_b_in   = head_b_ff;
      lead_in     = lead_ff;
      cmd         = '0;
      cmd.radix   = radix_ff;
      emit        = '0;
      req_stall   = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.radix = req_radix;
            if (req_valid) begin
               cmd.load    = 1'b1;
               radix_in    = req_radix;
               upper_in    = (req_kind == KIND_HEXU);
               lead_in     = 1'b1;
               head_cnt_in = 2'd0;
               head_a_in   = CHAR_ZERO;
               head_b_in   = (req_kind == KIND_HEXU) ? CHAR_X_UPPER : CHAR_X_LOWER;
               case (req_radix)
                  RADIX_DEC: begin
                     if (neg) begin
                        head_cnt_in = 2'd1;
                        head_a_in   = CHAR_MINUS;
                     end else if (req_show_plus) begin
                        head_cnt_in = 2'd1;
                        head_a_in   = CHAR_PLUS;
                     end else if (req_blank_plus) begin
                        head_cnt_in = 2'd1;
                        head_a_in   = CHAR_SPACE;
                     end
                  end
                  RADIX_OCT: head_cnt_in = req_alt_prefix ? 2'd1 : 2'd0;
                  RADIX_HEX: head_cnt_in = req_alt_prefix ? 2'd2 : 2'd0;
                  default:   head_cnt_in = 2'd0;
               endcase
               if (req_radix == RADIX_DEC) begin
                  state_in = ST_CONV;
                  cnt_in   = CW'(VALUE_BITS);
               end else begin
                  state_in = (head_cnt_in != 2'd0) ? ST_HEAD : ST_DIGS;
                  cnt_in   = dig_cnt;
               end
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = (head_cnt_ff != 2'd0) ? ST_HEAD : ST_DIGS;
               cnt_in   = dig_cnt;
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               emit.valid     = 1'b1;
               emit.text_char = head_a_ff;
               head_a_in      = head_b_ff;
               head_cnt_in    = head_cnt_ff - 2'd1;
               if (head_cnt_ff == 2'd1) begin
                  state_in = ST_DIGS;
               end
            end
         end
         ST_DIGS: begin
            if (lead_ff && digit == 4'd0 && cnt_ff != CW'(1)) begin
               cmd.shift = 1'b1;
               cnt_in    = cnt_ff - CW'(1);
            end else if (out_free) begin
               cmd.shift      = 1'b1;
               cnt_in         = cnt_ff - CW'(1);
               lead_in        = 1'b0;
               emit.valid     = 1'b1;
               emit.text_char = digit_char(digit, upper_ff);
               emit.last_char = (cnt_ff == CW'(1));
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         radix_ff    <= RADIX_DEC;
         upper_ff    <= 1'b0;
         cnt_ff      <= '0;
         head_cnt_ff <= 2'd0;
         lead_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         radix_ff    <= radix_in;
         upper_ff    <= upper_in;
         cnt_ff      <= cnt_in;
         head_cnt_ff <= head_cnt_in;
         lead_ff     <= lead_in;
      end
      head_a_ff <= head_a_in;
      head_b_ff <= head_b_in;
   end

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("character emitted while output register busy");

   a_digs_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGS |-> cnt_ff != '0)
      else $error("digit state with empty digit count");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      emit.valid && emit.last_char |=> state_ff == ST_IDLE)
      else $error("sequencer busy after final character");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("transaction accepted but sequencer idle");

   a_head_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HEAD && emit.valid |-> !emit.last_char)
      else $error("prefix character marked final");
`endif

endmodule
`default_nettype wire

[rtl/core/integer_to_ascii_formatter_unit.sv]
// Top level of the integer-to-ASCII formatter: sequencer, shift unit, output register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | kind, value, show_plus, blank_plus, alt_prefix
//   rsp     | out       | rsp_valid/rsp_stall | text_char, last_char
//
// Decimal: a load, the shift/add-3 conversion, then the sign character and the decimal
//   digit slots (leading zero slots skipped at one per cycle).
// Octal, hex, binary: a load, then the prefix characters and the digit slots.
// One bit or one digit moves through the shift unit per cycle, unless rsp_stall holds the output.
// Reset is synchronous and clears the sequencer and the output valid.
// rsp_stall holds a full output register and the sequencer's character emission; req_stall is high
//   until the final character has entered the output register.
`default_nettype none
module integer_to_ascii_formatter_unit #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [2:0]                          req_kind,
   input  wire logic [itoa_pkg::REQ_VALUE_BITS-1:0] req_value,
   input  wire logic                                req_show_plus,
   input  wire logic                                req_blank_plus,
   input  wire logic                                req_alt_prefix,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [7:0]                               rsp_text_char,
   output logic                                     rsp_last_char
);
   import itoa_pkg::*;

   conv_cmd_type          cmd;
   emit_type              emit;
   logic [VALUE_BITS-1:0] load_value;
   logic [3:0]            digit;
   logic                  out_free;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_text_char_ff, rsp_text_char_in;
   logic                  rsp_last_char_ff, rsp_last_char_in;

   itoa_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_show_plus  (req_show_plus),
      .req_blank_plus (req_blank_plus),
      .req_alt_prefix (req_alt_prefix),
      .out_free       (out_free),
      .digit          (digit),
      .cmd            (cmd),
      .load_value     (load_value),
      .emit           (emit)
   );

   itoa_conv #(.VALUE_BITS(VALUE_BITS)) u_conv (
      .clock      (clock),
      .cmd        (cmd),
      .load_value (load_value),
      .digit      (digit)
   );

   always_comb begin
      out_free         = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in     = emit.valid || (rsp_valid_ff && rsp_stall);
      rsp_text_char_in = emit.valid ? emit.text_char : rsp_text_char_ff;
      rsp_last_char_in = emit.valid ? emit.last_char : rsp_last_char_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_text_char_ff <= rsp_text_char_in;
      rsp_last_char_ff <= rsp_last_char_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_text_char_ff;
   assign rsp_last_char = rsp_last_char_ff;

endmodule
`default_nettype wire
